[hdl/bst_pkg.sv]
// shared constants, types and codes for the board status table
package bst_pkg;

	localparam int BOARDS     = 128;
	localparam int COIL_BYTES = 17;
	localparam int COIL_BITS  = COIL_BYTES * 8;
	localparam int ADDR_W     = (BOARDS > 1) ? $clog2(BOARDS) : 1;
	localparam int BI_W       = $clog2(COIL_BYTES);
	localparam int BIT_W      = $clog2(COIL_BITS);

	localparam logic [3:0] OP_STORE     = 4'd0;
	localparam logic [3:0] OP_MERGE     = 4'd1;
	localparam logic [3:0] OP_READ_BYTE = 4'd2;
	localparam logic [3:0] OP_READ_BIT  = 4'd3;
	localparam logic [3:0] OP_ONLINE    = 4'd4;
	localparam logic [3:0] OP_ALARMS    = 4'd5;
	localparam logic [3:0] OP_ZERO_HIT  = 4'd6;
	localparam logic [3:0] OP_ERROR     = 4'd7;
	localparam logic [3:0] OP_END_ROUND = 4'd8;

	localparam logic [31:0] STALE_ROUNDS = 32'd3;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [17:0] FLAG_LIMIT   = 18'd2;
	localparam logic [1:0]  LAST_SLOT    = 2'd2;

	typedef struct packed {
		logic [3:0] operation;
		logic [7:0] board;
		logic [7:0] byte_index;
		logic [9:0] bit_index;
		logic [3:0] merge_len;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic        zero_alarm;
		logic        addr_conflict;
	} result_t;

	typedef logic [COIL_BYTES-1:0][7:0] coil_t;

	typedef struct packed {
		logic        online;
		logic [31:0] last_seen;
		coil_t       coil;
	} row_t;

	typedef struct packed {
		logic              load;
		logic              end_round;
		logic              exec;
		logic              scan_rd;
		logic [ADDR_W-1:0] scan_addr;
		logic              finish;
	} ctl_cmd_t;

endpackage

[hdl/item_if.sv]
// input word channel
interface item_if import bst_pkg::*; ;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/result_if.sv]
// result word channel
interface result_if import bst_pkg::*; ;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/bst_ram.sv]
// generic single write port ram with registered read
module bst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hdl/bst_ctrl.sv]
// controller state machine: item sequencing, round walk and result handshake
module bst_ctrl import bst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     op_end,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	output ctl_cmd_t cmd
);
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_WALK  = 2'd2;
	localparam logic [1:0] S_DRAIN = 2'd3;
	localparam logic [ADDR_W-1:0] LAST_BOARD = ADDR_W'(BOARDS - 1);

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] walk_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.end_round = cmd.load && op_end;
		cmd.exec      = (state_q == S_EXEC);
		cmd.scan_rd   = (state_q == S_WALK);
		cmd.scan_addr = walk_q;
		cmd.finish    = cmd.exec || ((state_q == S_WALK) && (walk_q == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					walk_q <= '0;
					if (cmd.load) begin
						state_q <= op_end ? S_WALK : S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if (walk_q == LAST_BOARD) begin
						state_q <= S_DRAIN;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("ready outside idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q)
		else $error("result register overwritten");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (walk_q <= LAST_BOARD))
		else $error("walk beyond last board");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |=> (state_q == S_IDLE))
		else $error("drain did not return to idle");
endmodule

[hdl/bst_datapath.sv]
// datapath: row memory, round counters, histories and result register
module bst_datapath import bst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	input  item_t    in_item,
	output result_t  result
);
	localparam int ROW_W = $bits(row_t);

	item_t             item_q;
	logic [31:0]       round_q;
	logic [15:0]       err_q;
	logic [15:0]       zhit_q;
	logic [15:0]       err_hist_q [3];
	logic [15:0]       zhit_hist_q [3];
	logic [1:0]        slot_q;
	logic              conflict_q;
	logic              zero_q;
	logic [2**ADDR_W-1:0] row_valid_q;
	logic              valid_s1;
	logic              scan_s1;
	logic [ADDR_W-1:0] scan_idx_s1;
	result_t           result_q;

	logic [7:0]        in_bm1;
	logic [7:0]        q_bm1;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic              we;
	logic [ROW_W-1:0]  rdata;
	row_t              row_cur;
	row_t              row_new;
	row_t              row_wr;
	logic              ok;
	logic [63:0]       rv_c;
	logic [COIL_BITS-1:0] bits_c;
	logic [COIL_BITS-1:0] mmask;
	logic [COIL_BITS-1:0] mdata;
	logic [8:0]        one_sh;
	logic [7:0]        mask8;
	logic [1:0]        slot_eff;
	logic [15:0]       eh_n [3];
	logic [15:0]       zh_n [3];
	logic [17:0]       esum;
	logic [17:0]       zsum;

	assign in_bm1  = in_item.board - 8'd1;
	assign q_bm1   = item_q.board - 8'd1;
	assign rd_addr = cmd.load ? in_bm1[ADDR_W-1:0] : cmd.scan_addr;
	assign rd_en   = cmd.load || cmd.scan_rd;

	bst_ram #(.WIDTH(ROW_W), .DEPTH(BOARDS)) u_rows (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (row_wr),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign row_cur = valid_s1 ? row_t'(rdata) : row_t'('0);
	assign bits_c  = row_cur.coil;
	assign ok      = (item_q.board != 8'd0) && (item_q.board <= 8'(BOARDS));
	assign one_sh  = 9'd1 << item_q.merge_len[2:0];
	assign mask8   = (item_q.merge_len >= 4'd8) ? 8'hFF : one_sh[7:0] - 8'd1;
	assign mmask   = COIL_BITS'(mask8) << item_q.bit_index;
	assign mdata   = COIL_BITS'(item_q.data_byte & mask8) << item_q.bit_index;

	always_comb begin
		row_new = row_cur;
		rv_c    = '0;
		we      = 1'b0;
		wr_addr = q_bm1[ADDR_W-1:0];
		row_wr  = row_cur;
		case (item_q.operation)
			OP_STORE: begin
				if (item_q.byte_index < 8'(COIL_BYTES)) begin
					row_new.coil[item_q.byte_index[BI_W-1:0]] = item_q.data_byte;
				end
				row_new.online    = 1'b1;
				row_new.last_seen = round_q;
				we                = ok;
			end
			OP_MERGE: begin
				row_new.coil      = (bits_c & ~mmask) | mdata;
				row_new.online    = 1'b1;
				row_new.last_seen = round_q;
				we                = ok;
			end
			OP_READ_BYTE: begin
				if (ok && (item_q.byte_index < 8'(COIL_BYTES))) begin
					rv_c = 64'(row_cur.coil[item_q.byte_index[BI_W-1:0]]);
				end
			end
			OP_READ_BIT: begin
				if (ok && (item_q.bit_index < 10'(COIL_BITS))) begin
					rv_c = 64'(bits_c[item_q.bit_index[BIT_W-1:0]]);
				end
			end
			OP_ONLINE: begin
				if (ok) begin
					rv_c = 64'(row_cur.online);
				end
			end
			OP_ALARMS: begin
				if (ok) begin
					rv_c = {bits_c[125:63], bits_c[129]};
				end
			end
			default: begin
				rv_c = '0;
			end
		endcase
		we     = we && cmd.exec;
		row_wr = row_new;
		if (scan_s1) begin
			we      = 1'b1;
			wr_addr = scan_idx_s1;
			row_wr  = row_cur;
			if ((row_cur.last_seen + STALE_ROUNDS) <= round_q) begin
				row_wr.online = 1'b0;
			end
		end
	end

	always_comb begin
		slot_eff = (slot_q > LAST_SLOT) ? 2'd0 : slot_q;
		eh_n     = err_hist_q;
		zh_n     = zhit_hist_q;
		eh_n[slot_eff] = err_q;
		zh_n[slot_eff] = zhit_q;
		esum = 18'(eh_n[0]) + 18'(eh_n[1]) + 18'(eh_n[2]);
		zsum = 18'(zh_n[0]) + 18'(zh_n[1]) + 18'(zh_n[2]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.finish) begin
			result_q.read_value    <= rv_c;
			result_q.zero_alarm    <= zero_q;
			result_q.addr_conflict <= conflict_q;
		end
		scan_idx_s1 <= cmd.scan_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q     <= '0;
			err_q       <= '0;
			zhit_q      <= '0;
			err_hist_q  <= '{default: '0};
			zhit_hist_q <= '{default: '0};
			slot_q      <= '0;
			conflict_q  <= 1'b0;
			zero_q      <= 1'b0;
			row_valid_q <= '0;
			valid_s1    <= 1'b0;
			scan_s1     <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			if (rd_en) begin
				valid_s1 <= row_valid_q[rd_addr];
			end
			if (we) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.exec && (item_q.operation == OP_ZERO_HIT) && (zhit_q != COUNT_MAX)) begin
				zhit_q <= zhit_q + 16'd1;
			end
			if (cmd.exec && (item_q.operation == OP_ERROR) && (err_q != COUNT_MAX)) begin
				err_q <= err_q + 16'd1;
			end
			if (cmd.end_round) begin
				round_q     <= round_q + 32'd1;
				err_hist_q  <= eh_n;
				zhit_hist_q <= zh_n;
				err_q       <= '0;
				zhit_q      <= '0;
				slot_q      <= (slot_eff == LAST_SLOT) ? 2'd0 : slot_eff + 2'd1;
				conflict_q  <= (esum > FLAG_LIMIT);
				zero_q      <= (zsum > FLAG_LIMIT);
			end
		end
	end

	assign result = result_q;
endmodule

[hdl/board_status_table.sv]
// board status table top level
//
// items (sink) carries one command word per transfer; results (source)
// returns exactly one result word per command, in order.
// a command is taken only while the block is idle and the result register
// is free or being emptied in the same cycle.
// store, merge, reads and counts: the row of the addressed board is read
// from the row memory at the accept edge, then modified, written back and
// the result registered in the exec state.
// at end of round the walk reads one row per cycle and writes back the
// aged online flag in the cycle after each read; its result word is issued
// at the start of the walk.
// a new command is taken only after the previous one has executed, limited
// by the single read-modify-write of the row memory.
// at reset all rows read as zero through per-row valid bits, so no
// clearing pass is needed and commands are accepted right away.
// a stalled receiver holds the result word; the next command waits until
// the result register can be emptied.
module board_status_table import bst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	item_if.sink       items,
	result_if.source   results
);
	ctl_cmd_t cmd;
	logic     in_ready;
	logic     out_valid;
	result_t  result;

	bst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.op_end    (items.data.operation == OP_END_ROUND),
		.in_ready  (in_ready),
		.out_ready (results.ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	bst_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (items.data),
		.result  (result)
	);

	assign items.ready   = in_ready;
	assign results.valid = out_valid;
	assign results.data  = result;
endmodule
